### src/idxh_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status codes, control structs and the rank compare of the heap.
package idxh_pkg;

	localparam int ELEMENTS   = 16384;
	localparam int HEAP_DEPTH = 16384;
	localparam int ELEM_W     = 14;
	localparam int SLOT_W     = 14;
	localparam int CNT_W      = 15;
	localparam int KEY_W      = 32;
	localparam int TAG_W      = 32;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_ERASE  = 3'd1;
	localparam logic [2:0] CMD_UPDATE = 3'd2;
	localparam logic [2:0] CMD_POP    = 3'd3;
	localparam logic [2:0] CMD_LOCATE = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	// Slot memory read address sources.
	localparam logic [2:0] SA_P      = 3'd0;
	localparam logic [2:0] SA_POSR   = 3'd1;
	localparam logic [2:0] SA_LAST   = 3'd2;
	localparam logic [2:0] SA_CNT    = 3'd3;
	localparam logic [2:0] SA_PARENT = 3'd4;
	localparam logic [2:0] SA_LEFT   = 3'd5;
	localparam logic [2:0] SA_RIGHT  = 3'd6;

	localparam logic EA_E    = 1'b0;
	localparam logic EA_SLOT = 1'b1;

	localparam logic [1:0] EW_NONE = 2'd0;
	localparam logic [1:0] EW_INS  = 2'd1;
	localparam logic [1:0] EW_UPD  = 2'd2;

	localparam logic [1:0] SW_NONE = 2'd0;
	localparam logic [1:0] SW_UP   = 2'd1;
	localparam logic [1:0] SW_BEST = 2'd2;
	localparam logic [1:0] SW_M    = 2'd3;

	localparam logic [2:0] I_HOLD   = 3'd0;
	localparam logic [2:0] I_COUNT  = 3'd1;
	localparam logic [2:0] I_P      = 3'd2;
	localparam logic [2:0] I_PARENT = 3'd3;
	localparam logic [2:0] I_BEST   = 3'd4;

	localparam logic [1:0] C_HOLD = 2'd0;
	localparam logic [1:0] C_INC  = 2'd1;
	localparam logic [1:0] C_DEC  = 2'd2;
	localparam logic [1:0] C_CLR  = 2'd3;

	localparam logic [2:0] M_HOLD   = 3'd0;
	localparam logic [2:0] M_INS    = 3'd1;
	localparam logic [2:0] M_UPD    = 3'd2;
	localparam logic [2:0] M_LAST   = 3'd3;
	localparam logic [2:0] M_LASTKT = 3'd4;

	localparam logic [1:0] B_HOLD  = 2'd0;
	localparam logic [1:0] B_INIT  = 2'd1;
	localparam logic [1:0] B_LEFT  = 2'd2;
	localparam logic [1:0] B_RIGHT = 2'd3;

	localparam logic [1:0] R_NONE = 2'd0;
	localparam logic [1:0] R_TAKE = 2'd1;
	localparam logic [1:0] R_M    = 2'd2;
	localparam logic [1:0] R_LOC  = 2'd3;

	typedef struct packed {
		logic       load;
		logic [2:0] slot_ra;
		logic       elem_ra;
		logic [1:0] elem_wr;
		logic [1:0] slot_wr;
		logic [2:0] i_op;
		logic [1:0] cnt_op;
		logic [2:0] m_op;
		logic [1:0] best_op;
		logic [1:0] res_op;
		logic       moved_set;
		logic       set_status;
		logic [1:0] status_code;
	} ctrl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       full;
		logic       empty;
		logic       pos_bad;
		logic       present;
		logic       up_above;
		logic       i_zero;
		logic       left_out;
		logic       right_out;
		logic       best_at_i;
		logic       last_at_p;
		logic       moved;
	} stat_t;

	// True when element a must sit above element b under the given mode.
	function automatic logic above(input logic mode,
			input logic signed [KEY_W-1:0] ka, input logic [TAG_W-1:0] ta,
			input logic signed [KEY_W-1:0] kb, input logic [TAG_W-1:0] tb);
		logic a_over_b;
		logic b_over_a;
		a_over_b = (ka > kb) || ((ka == kb) && (ta < tb));
		b_over_a = (kb > ka) || ((ka == kb) && (tb < ta));
		return mode ? a_over_b : b_over_a;
	endfunction

endpackage

### src/indexed_binary_heap.sv
`timescale 1ns / 1ps
// Indexed binary heap priority queue: top level joining sequencer and datapath.
//
// A command is taken when start is high and busy is low; busy then stays high until its
// result has been shown. The result appears for exactly one cycle with done high and
// cannot be held off. Every sift level reads its slot and then that element's key/tag
// entry one after another through the single read port of the slot and element memories,
// so each level climbed passes S_UP_RD, S_UP_E and S_UP_CMP, and each level sunk S_DN_L up
// to S_DN_DEC. Before sifting an insert passes the dispatch and two check states, an update
// the dispatch and two read states, and an erase or a pop two more states to fetch the last
// element. The longest command is a pop or an erase that sinks from the root down all
// thirteen levels below the root of a full heap; no new command is taken until busy falls.
// The heap mode may be written on the configuration channel, which is always ready,
// while no command is in progress.
module indexed_binary_heap import idxh_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              command,
	input  logic [ELEM_W-1:0]       element,
	input  logic [SLOT_W-1:0]       position,
	input  logic signed [KEY_W-1:0] point,
	input  logic [TAG_W-1:0]        tag,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data,
	output logic                    done,
	output logic [ELEM_W-1:0]       out_element,
	output logic signed [KEY_W-1:0] out_point,
	output logic [TAG_W-1:0]        out_tag,
	output logic [SLOT_W-1:0]       out_position,
	output logic [CNT_W-1:0]        count,
	output logic [1:0]              status
);

	ctrl_t ctl;
	stat_t st;

	assign cfg_ready = 1'b1;

	idxh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	idxh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg_we       (cfg_valid),
		.cfg_mode     (cfg_data),
		.command      (command),
		.element      (element),
		.position     (position),
		.point        (point),
		.tag          (tag),
		.st           (st),
		.out_element  (out_element),
		.out_point    (out_point),
		.out_tag      (out_tag),
		.out_position (out_position),
		.count        (count),
		.status       (status)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown outside a command");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item not taken up");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(HEAP_DEPTH))
		else $error("heap count beyond depth");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |->
		((out_element == '0) && (out_point == '0) && (out_tag == '0) && (out_position == '0)))
		else $error("failed command shows element data");

endmodule

### src/idxh_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer of the heap: checks, sift up and sift down steps.
module idxh_ctrl import idxh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t st,
	output ctrl_t ctl,
	output logic  busy,
	output logic  done
);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DISPATCH = 5'd1;
	localparam logic [4:0] S_CHK_SLOT = 5'd2;
	localparam logic [4:0] S_CHK_CMP  = 5'd3;
	localparam logic [4:0] S_LOC_DONE = 5'd4;
	localparam logic [4:0] S_RD_E     = 5'd5;
	localparam logic [4:0] S_RD_K     = 5'd6;
	localparam logic [4:0] S_RD_L     = 5'd7;
	localparam logic [4:0] S_RD_LK    = 5'd8;
	localparam logic [4:0] S_UP_RD    = 5'd9;
	localparam logic [4:0] S_UP_E     = 5'd10;
	localparam logic [4:0] S_UP_CMP   = 5'd11;
	localparam logic [4:0] S_DN_L     = 5'd12;
	localparam logic [4:0] S_DN_LE    = 5'd13;
	localparam logic [4:0] S_DN_LC    = 5'd14;
	localparam logic [4:0] S_DN_RE    = 5'd15;
	localparam logic [4:0] S_DN_RC    = 5'd16;
	localparam logic [4:0] S_DN_DEC   = 5'd17;
	localparam logic [4:0] S_DN_END   = 5'd18;
	localparam logic [4:0] S_PLACE    = 5'd19;
	localparam logic [4:0] S_FINISH   = 5'd20;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic [4:0] up_end;

	// Where a sift up ends: an update that did not climb goes on to sink.
	assign up_end = ((st.cmd == CMD_UPDATE) && !st.moved) ? S_DN_L : S_PLACE;

	always_comb begin
		ctl = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (st.cmd) inside
					CMD_INSERT: begin
						if (st.full) begin
							ctl.set_status = 1'b1;
							ctl.status_code = ST_FULL;
							state_d = S_FINISH;
						end else begin
							state_d = S_CHK_SLOT;
						end
					end
					CMD_LOCATE: state_d = S_CHK_SLOT;
					CMD_ERASE, CMD_UPDATE: begin
						if (st.pos_bad) begin
							ctl.set_status = 1'b1;
							ctl.status_code = ST_BAD;
							state_d = S_FINISH;
						end else begin
							ctl.slot_ra = SA_P;
							state_d = S_RD_E;
						end
					end
					CMD_POP: begin
						if (st.empty) begin
							ctl.set_status = 1'b1;
							ctl.status_code = ST_EMPTY;
							state_d = S_FINISH;
						end else begin
							ctl.slot_ra = SA_P;
							state_d = S_RD_E;
						end
					end
					CMD_CLEAR: begin
						ctl.cnt_op = C_CLR;
						state_d = S_FINISH;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_CHK_SLOT: begin
				ctl.slot_ra = SA_POSR;
				state_d = S_CHK_CMP;
			end
			S_CHK_CMP: begin
				if (st.cmd == CMD_INSERT) begin
					if (st.present) begin
						ctl.set_status = 1'b1;
						ctl.status_code = ST_BAD;
						state_d = S_FINISH;
					end else begin
						ctl.elem_wr = EW_INS;
						ctl.m_op = M_INS;
						ctl.i_op = I_COUNT;
						ctl.cnt_op = C_INC;
						state_d = S_UP_RD;
					end
				end else begin
					if (st.present) begin
						ctl.elem_ra = EA_E;
						state_d = S_LOC_DONE;
					end else begin
						ctl.set_status = 1'b1;
						ctl.status_code = ST_BAD;
						state_d = S_FINISH;
					end
				end
			end
			S_LOC_DONE: begin
				ctl.res_op = R_LOC;
				state_d = S_FINISH;
			end
			S_RD_E: begin
				ctl.slot_ra = SA_P;
				ctl.elem_ra = EA_SLOT;
				state_d = S_RD_K;
			end
			S_RD_K: begin
				if (st.cmd == CMD_UPDATE) begin
					ctl.elem_wr = EW_UPD;
					ctl.m_op = M_UPD;
					ctl.i_op = I_P;
					state_d = S_UP_RD;
				end else begin
					ctl.res_op = R_TAKE;
					ctl.cnt_op = C_DEC;
					if (st.last_at_p) begin
						state_d = S_FINISH;
					end else begin
						ctl.slot_ra = SA_LAST;
						state_d = S_RD_L;
					end
				end
			end
			S_RD_L: begin
				ctl.slot_ra = SA_CNT;
				ctl.elem_ra = EA_SLOT;
				ctl.m_op = M_LAST;
				state_d = S_RD_LK;
			end
			S_RD_LK: begin
				ctl.m_op = M_LASTKT;
				ctl.i_op = I_P;
				state_d = S_DN_L;
			end
			S_UP_RD: begin
				if (st.i_zero) begin
					state_d = up_end;
				end else begin
					ctl.slot_ra = SA_PARENT;
					state_d = S_UP_E;
				end
			end
			S_UP_E: begin
				ctl.slot_ra = SA_PARENT;
				ctl.elem_ra = EA_SLOT;
				state_d = S_UP_CMP;
			end
			S_UP_CMP: begin
				if (st.up_above) begin
					ctl.slot_wr = SW_UP;
					ctl.i_op = I_PARENT;
					ctl.moved_set = 1'b1;
					state_d = S_UP_RD;
				end else begin
					state_d = up_end;
				end
			end
			S_DN_L: begin
				if (st.left_out) begin
					state_d = S_DN_END;
				end else begin
					ctl.best_op = B_INIT;
					ctl.slot_ra = SA_LEFT;
					state_d = S_DN_LE;
				end
			end
			S_DN_LE: begin
				ctl.slot_ra = SA_LEFT;
				ctl.elem_ra = EA_SLOT;
				state_d = S_DN_LC;
			end
			S_DN_LC: begin
				ctl.best_op = B_LEFT;
				if (st.right_out) begin
					state_d = S_DN_DEC;
				end else begin
					ctl.slot_ra = SA_RIGHT;
					state_d = S_DN_RE;
				end
			end
			S_DN_RE: begin
				ctl.slot_ra = SA_RIGHT;
				ctl.elem_ra = EA_SLOT;
				state_d = S_DN_RC;
			end
			S_DN_RC: begin
				ctl.best_op = B_RIGHT;
				state_d = S_DN_DEC;
			end
			S_DN_DEC: begin
				if (st.best_at_i) begin
					state_d = S_DN_END;
				end else begin
					ctl.slot_wr = SW_BEST;
					ctl.i_op = I_BEST;
					ctl.moved_set = 1'b1;
					state_d = S_DN_L;
				end
			end
			S_DN_END: begin
				// An erased slot whose filler did not sink may have to climb instead.
				if ((st.cmd == CMD_ERASE) && !st.moved) begin
					state_d = S_UP_RD;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				ctl.slot_wr = SW_M;
				if ((st.cmd == CMD_INSERT) || (st.cmd == CMD_UPDATE)) begin
					ctl.res_op = R_M;
				end
				state_d = S_FINISH;
			end
			S_FINISH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FINISH);

endmodule

### src/idxh_dp.sv
`timescale 1ns / 1ps
// Heap datapath: slot, position and element memories, sift registers and result registers.
module idxh_dp import idxh_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_t                   ctl,
	input  logic                    cfg_we,
	input  logic                    cfg_mode,
	input  logic [2:0]              command,
	input  logic [ELEM_W-1:0]       element,
	input  logic [SLOT_W-1:0]       position,
	input  logic signed [KEY_W-1:0] point,
	input  logic [TAG_W-1:0]        tag,
	output stat_t                   st,
	output logic [ELEM_W-1:0]       out_element,
	output logic signed [KEY_W-1:0] out_point,
	output logic [TAG_W-1:0]        out_tag,
	output logic [SLOT_W-1:0]       out_position,
	output logic [CNT_W-1:0]        count,
	output logic [1:0]              status
);

	localparam int WW = SLOT_W + 2;

	logic [ELEM_W-1:0] slot_mem [HEAP_DEPTH];
	logic [SLOT_W-1:0] pos_mem [ELEMENTS];
	logic [KEY_W+TAG_W-1:0] elem_mem [ELEMENTS];

	logic [ELEM_W-1:0]      slot_rd_q;
	logic [SLOT_W-1:0]      pos_rd_q;
	logic [KEY_W+TAG_W-1:0] elem_rd_q;

	logic                    mode_q;
	logic [CNT_W-1:0]        count_q;
	logic [2:0]              cmd_q;
	logic                    moved_q;
	logic [1:0]              res_status_q;
	logic [ELEM_W-1:0]       e_q;
	logic [SLOT_W-1:0]       p_q;
	logic signed [KEY_W-1:0] key_q;
	logic [TAG_W-1:0]        tag_q;
	logic [ELEM_W-1:0]       m_e_q;
	logic signed [KEY_W-1:0] m_key_q;
	logic [TAG_W-1:0]        m_tag_q;
	logic [SLOT_W-1:0]       i_q;
	logic [ELEM_W-1:0]       best_e_q;
	logic signed [KEY_W-1:0] best_key_q;
	logic [TAG_W-1:0]        best_tag_q;
	logic [SLOT_W-1:0]       best_pos_q;
	logic [ELEM_W-1:0]       res_e_q;
	logic signed [KEY_W-1:0] res_key_q;
	logic [TAG_W-1:0]        res_tag_q;
	logic [SLOT_W-1:0]       res_pos_q;

	logic signed [KEY_W-1:0] ek;
	logic [TAG_W-1:0]        et;
	logic [SLOT_W-1:0]       i_m1;
	logic [SLOT_W-1:0]       parent;
	logic [SLOT_W:0]         left;
	logic [WW-1:0]           right;
	logic [CNT_W-1:0]        cnt_m1;
	logic [SLOT_W-1:0]       slot_ra;
	logic [ELEM_W-1:0]       elem_ra;
	logic                    slot_we;
	logic [ELEM_W-1:0]       slot_wd;
	logic                    elem_we;
	logic [ELEM_W-1:0]       elem_wa;
	logic [KEY_W+TAG_W-1:0]  elem_wd;
	logic                    dn_above;

	assign ek = elem_rd_q[KEY_W+TAG_W-1:TAG_W];
	assign et = elem_rd_q[TAG_W-1:0];
	assign i_m1 = i_q - SLOT_W'(1);
	assign parent = i_m1 >> 1;
	assign left = {i_q, 1'b1};
	assign right = WW'(left) + WW'(1);
	assign cnt_m1 = count_q - CNT_W'(1);

	always_comb begin
		case (ctl.slot_ra)
			SA_P:      slot_ra = p_q;
			SA_POSR:   slot_ra = pos_rd_q;
			SA_LAST:   slot_ra = cnt_m1[SLOT_W-1:0];
			SA_CNT:    slot_ra = count_q[SLOT_W-1:0];
			SA_PARENT: slot_ra = parent;
			SA_LEFT:   slot_ra = left[SLOT_W-1:0];
			SA_RIGHT:  slot_ra = right[SLOT_W-1:0];
			default:   slot_ra = p_q;
		endcase
	end

	assign elem_ra = (ctl.elem_ra == EA_SLOT) ? slot_rd_q : e_q;

	always_comb begin
		slot_we = 1'b1;
		case (ctl.slot_wr)
			SW_UP:   slot_wd = slot_rd_q;
			SW_BEST: slot_wd = best_e_q;
			SW_M:    slot_wd = m_e_q;
			default: begin
				slot_we = 1'b0;
				slot_wd = m_e_q;
			end
		endcase
	end

	always_comb begin
		elem_we = 1'b1;
		case (ctl.elem_wr)
			EW_INS: begin
				elem_wa = e_q;
				elem_wd = {key_q, tag_q};
			end
			EW_UPD: begin
				elem_wa = slot_rd_q;
				elem_wd = {key_q, et};
			end
			default: begin
				elem_we = 1'b0;
				elem_wa = e_q;
				elem_wd = {key_q, tag_q};
			end
		endcase
	end

	// A slot write always carries the matching position write for the element moved.
	always_ff @(posedge clk) begin
		slot_rd_q <= slot_mem[slot_ra];
		if (slot_we) begin
			slot_mem[i_q] <= slot_wd;
		end
	end

	always_ff @(posedge clk) begin
		pos_rd_q <= pos_mem[e_q];
		if (slot_we) begin
			pos_mem[slot_wd] <= i_q;
		end
	end

	always_ff @(posedge clk) begin
		elem_rd_q <= elem_mem[elem_ra];
		if (elem_we) begin
			elem_mem[elem_wa] <= elem_wd;
		end
	end

	assign dn_above = above(mode_q, ek, et, best_key_q, best_tag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			count_q <= '0;
			cmd_q <= CMD_INSERT;
			moved_q <= 1'b0;
			res_status_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
			case (ctl.cnt_op)
				C_INC:   count_q <= count_q + CNT_W'(1);
				C_DEC:   count_q <= cnt_m1;
				C_CLR:   count_q <= '0;
				default: count_q <= count_q;
			endcase
			if (ctl.load) begin
				cmd_q <= command;
				moved_q <= 1'b0;
				res_status_q <= ST_OK;
			end else begin
				if (ctl.moved_set) begin
					moved_q <= 1'b1;
				end
				if (ctl.set_status) begin
					res_status_q <= ctl.status_code;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			e_q <= element;
			p_q <= (command == CMD_POP) ? '0 : position;
			key_q <= point;
			tag_q <= tag;
		end
		case (ctl.i_op)
			I_COUNT:  i_q <= count_q[SLOT_W-1:0];
			I_P:      i_q <= p_q;
			I_PARENT: i_q <= parent;
			I_BEST:   i_q <= best_pos_q;
			default:  i_q <= i_q;
		endcase
		case (ctl.m_op)
			M_INS: begin
				m_e_q <= e_q;
				m_key_q <= key_q;
				m_tag_q <= tag_q;
			end
			M_UPD: begin
				m_e_q <= slot_rd_q;
				m_key_q <= key_q;
				m_tag_q <= et;
			end
			M_LAST: m_e_q <= slot_rd_q;
			M_LASTKT: begin
				m_key_q <= ek;
				m_tag_q <= et;
			end
			default: ;
		endcase
		case (ctl.best_op)
			B_INIT: begin
				best_e_q <= m_e_q;
				best_key_q <= m_key_q;
				best_tag_q <= m_tag_q;
				best_pos_q <= i_q;
			end
			B_LEFT: begin
				if (dn_above) begin
					best_e_q <= slot_rd_q;
					best_key_q <= ek;
					best_tag_q <= et;
					best_pos_q <= left[SLOT_W-1:0];
				end
			end
			B_RIGHT: begin
				if (dn_above) begin
					best_e_q <= slot_rd_q;
					best_key_q <= ek;
					best_tag_q <= et;
					best_pos_q <= right[SLOT_W-1:0];
				end
			end
			default: ;
		endcase
		if (ctl.load) begin
			res_e_q <= '0;
			res_key_q <= '0;
			res_tag_q <= '0;
			res_pos_q <= '0;
		end else begin
			case (ctl.res_op)
				R_TAKE: begin
					res_e_q <= slot_rd_q;
					res_key_q <= ek;
					res_tag_q <= et;
				end
				R_M: begin
					res_e_q <= m_e_q;
					res_key_q <= m_key_q;
					res_tag_q <= m_tag_q;
					res_pos_q <= i_q;
				end
				R_LOC: begin
					res_e_q <= e_q;
					res_key_q <= ek;
					res_tag_q <= et;
					res_pos_q <= pos_rd_q;
				end
				default: ;
			endcase
		end
	end

	assign st.cmd = cmd_q;
	assign st.full = (count_q >= CNT_W'(HEAP_DEPTH));
	assign st.empty = (count_q == '0);
	assign st.pos_bad = (WW'(p_q) >= WW'(count_q));
	assign st.present = (WW'(pos_rd_q) < WW'(count_q)) && (slot_rd_q == e_q);
	assign st.up_above = above(mode_q, m_key_q, m_tag_q, ek, et);
	assign st.i_zero = (i_q == '0);
	assign st.left_out = (WW'(left) >= WW'(count_q));
	assign st.right_out = (right >= WW'(count_q));
	assign st.best_at_i = (best_pos_q == i_q);
	assign st.last_at_p = ((WW'(p_q) + WW'(1)) == WW'(count_q));
	assign st.moved = moved_q;

	assign out_element = res_e_q;
	assign out_point = res_key_q;
	assign out_tag = res_tag_q;
	assign out_position = res_pos_q;
	assign count = count_q;
	assign status = res_status_q;

endmodule
